// ===== hw/rtl/iobrt_pkg.sv =====
// Shared types and constants of the I/O buffer reorder tracker.
// Used by the channel interfaces and by the tracker unit; the RAM does not use it.
package iobrt_pkg;

  localparam int unsigned SLOTS   = 16;
  localparam int unsigned SLOT_W  = $clog2(SLOTS);
  localparam int unsigned CNT_W   = SLOT_W + 1;
  localparam int unsigned ORDER_W = 32;

  // Operation codes of an input transaction.
  typedef logic [3:0] op_t;
  localparam op_t OP_TAKE_FREE     = 4'd0;
  localparam op_t OP_READ_DONE     = 4'd1;
  localparam op_t OP_TAKE_FULL     = 4'd2;
  localparam op_t OP_WRITE_DONE    = 4'd3;
  localparam op_t OP_TAKE_FINISHED = 4'd4;
  localparam op_t OP_MARK_COMPLETE = 4'd5;
  localparam op_t OP_RETURN_FREE   = 4'd6;
  localparam op_t OP_RESTART       = 4'd7;
  localparam op_t OP_FORCE_HOME    = 4'd8;

  // Result status codes.
  typedef logic [2:0] stat_t;
  localparam stat_t ST_OK       = 3'd0;
  localparam stat_t ST_NONE     = 3'd1;
  localparam stat_t ST_DUP      = 3'd2;
  localparam stat_t ST_IN_USE   = 3'd3;
  localparam stat_t ST_BAD_SLOT = 3'd4;

  // I/O status codes of a completion.
  localparam logic [1:0] IO_OK  = 2'd0;
  localparam logic [1:0] IO_EOF = 2'd1;

  typedef enum logic [1:0] {
    PH_FREE = 2'd0,
    PH_OUT  = 2'd1,
    PH_FULL = 2'd2,
    PH_FIN  = 2'd3
  } phase_e;

  typedef struct packed {
    logic [3:0]  operation;
    logic [3:0]  slot;
    logic [1:0]  io_status;
    logic        status_eof;
    logic [31:0] bytes_done;
    logic [31:0] bytes_requested;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot_out;
    logic [31:0] order_out;
    logic        last_part;
    logic        io_failed;
    logic        read_possible;
    logic        write_possible;
    logic        finished_ready;
    logic        all_home;
  } rsp_t;

endpackage

// ===== hw/rtl/iobrt_if.sv =====
// Valid/ready channel interfaces of the I/O buffer reorder tracker.
// Depends on iobrt_pkg for the payload types.
interface iobrt_req_if import iobrt_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface iobrt_rsp_if import iobrt_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/iobrt_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Stands alone; no package is needed.
module iobrt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hw/rtl/io_buffer_reorder_tracker_unit.sv =====
// I/O buffer reorder tracker: pool of buffer slots moved through free, out, full, finished.
// Depends on iobrt_pkg, the iobrt_req_if/iobrt_rsp_if interfaces and iobrt_ram.
//
// Usage. Each operation arrives as one transaction on req_i and produces exactly one
// transaction on rsp_o carrying a status, the handed-out slot with its order tag, and the
// readiness flags of the pool. The user writes the buffer_count register through cfg_we_i
// and cfg_wdata_i only while the block is idle; the block does not enforce this. Growing
// the pool appends new slots to the free list one slot per cycle, taking no transaction.
// The block works on one transaction at a time. The order tags live in a RAM with
// registered read data, and every operation ends with a scan over the slots in use, one slot
// per cycle, which refreshes the cached oldest full and finished slots and the home test.
// Restart, once the source is done, and force home drain slots one by one, each drained slot
// costing one further scan.
// Reset places all sixteen slots on the free list in ascending order, clears all orders and
// flags, and leaves the tag RAM undefined; no clearing pass is needed.
// A result waits in the output register while the receiver stalls; the next transaction is
// still accepted and is processed, but its result is held until the register is freed.
module io_buffer_reorder_tracker_unit
  import iobrt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [4:0]         cfg_wdata_i,
  iobrt_req_if.sink          req_i,
  iobrt_rsp_if.source        rsp_o
);

  // Sequencer state codes.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_RST  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;
  localparam logic [2:0] S_GROW = 3'd5;

  // Scan purposes.
  localparam logic [1:0] M_FLAGS = 2'd0;
  localparam logic [1:0] M_CLASH = 2'd1;
  localparam logic [1:0] M_DRAIN = 2'd2;

  logic [2:0] state_q, state_d;

  // Pool registers.
  logic [CNT_W-1:0]   count_q, count_d;
  logic [SLOT_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]   total_q, total_d;
  logic [ORDER_W-1:0] nro_q, nro_d, nwo_q, nwo_d, nfo_q, nfo_d;
  logic               src_done_q, src_done_d, wr_done_q, wr_done_d;
  phase_e             phase_q [SLOTS];
  phase_e             phase_d [SLOTS];
  logic [SLOTS-1:0]   final_q, final_d, fault_q, fault_d;
  // A free-list entry that was never written since reset or shrink holds its own position.
  logic [SLOTS-1:0]   flv_q, flv_d;
  logic [CNT_W-1:0]   grow_q, grow_d;

  // Latched transaction.
  op_t                op_q, op_d;
  logic [3:0]         slot_q, slot_d;
  logic               rd_last_q, rd_last_d, rd_fault_q, rd_fault_d, wr_fault_q, wr_fault_d;
  logic [ORDER_W-1:0] key_q, key_d;

  // Cached oldest full and finished slots and home test from the last flag scan.
  logic               full_hit_q, full_hit_d, fin_hit_q, fin_hit_d, home_q, home_d;
  logic [SLOT_W-1:0]  full_idx_q, full_idx_d, fin_idx_q, fin_idx_d;
  logic [ORDER_W-1:0] full_tag_q, full_tag_d, fin_tag_q, fin_tag_d;

  // Scan engine.
  logic [1:0]         mode_q, mode_d;
  phase_e             a_ph_q, a_ph_d;
  logic               a_nf_q, a_nf_d;
  logic [CNT_W-1:0]   scan_c_q, scan_c_d;
  logic               pv_q, pv_d;
  logic [SLOT_W-1:0]  pidx_q, pidx_d;
  logic               a_found_q, a_found_d, b_found_q, b_found_d, clash_q, clash_d;
  logic [SLOT_W-1:0]  a_idx_q, a_idx_d, b_idx_q, b_idx_d;
  logic [ORDER_W-1:0] a_tag_q, a_tag_d, b_tag_q, b_tag_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  // Result being built and the output register.
  stat_t              res_st_q, res_st_d;
  logic [3:0]         res_slot_q, res_slot_d;
  logic [ORDER_W-1:0] res_ord_q, res_ord_d;
  logic               res_lp_q, res_lp_d, res_fl_q, res_fl_d;
  logic               rsp_valid_q, rsp_valid_d;
  rsp_t               rsp_q, rsp_d;

  // Memory ports.
  logic               tag_we;
  logic [SLOT_W-1:0]  tag_waddr, tag_raddr;
  logic [ORDER_W-1:0] tag_wdata, tag_rdata;
  logic               fl_we;
  logic [SLOT_W-1:0]  fl_waddr, fl_wdata, fl_rdata;

  iobrt_ram #(.WIDTH(ORDER_W), .DEPTH(SLOTS)) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (tag_waddr),
    .wdata_i (tag_wdata),
    .raddr_i (tag_raddr),
    .rdata_o (tag_rdata)
  );

  iobrt_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (fl_we),
    .waddr_i (fl_waddr),
    .wdata_i (fl_wdata),
    .raddr_i (head_q),
    .rdata_o (fl_rdata)
  );

  assign req_i.ready   = (state_q == S_IDLE);
  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

  logic               start_scan;
  logic               push_en;
  logic [SLOT_W-1:0]  push_slot;
  logic [SLOT_W-1:0]  take_idx;
  logic               slot_ok;
  phase_e             tgt_ph;
  logic [CNT_W-1:0]   cfg_n;
  logic [CNT_W:0]     home_sum;
  phase_e             cur_ph;

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    head_d     = head_q;
    total_d    = total_q;
    nro_d      = nro_q;
    nwo_d      = nwo_q;
    nfo_d      = nfo_q;
    src_done_d = src_done_q;
    wr_done_d  = wr_done_q;
    phase_d    = phase_q;
    final_d    = final_q;
    fault_d    = fault_q;
    flv_d      = flv_q;
    grow_d     = grow_q;
    op_d       = op_q;
    slot_d     = slot_q;
    rd_last_d  = rd_last_q;
    rd_fault_d = rd_fault_q;
    wr_fault_d = wr_fault_q;
    key_d      = key_q;
    full_hit_d = full_hit_q;
    full_idx_d = full_idx_q;
    full_tag_d = full_tag_q;
    fin_hit_d  = fin_hit_q;
    fin_idx_d  = fin_idx_q;
    fin_tag_d  = fin_tag_q;
    home_d     = home_q;
    mode_d     = mode_q;
    a_ph_d     = a_ph_q;
    a_nf_d     = a_nf_q;
    scan_c_d   = scan_c_q;
    pv_d       = pv_q;
    pidx_d     = pidx_q;
    a_found_d  = a_found_q;
    a_idx_d    = a_idx_q;
    a_tag_d    = a_tag_q;
    b_found_d  = b_found_q;
    b_idx_d    = b_idx_q;
    b_tag_d    = b_tag_q;
    cnt_d      = cnt_q;
    clash_d    = clash_q;
    res_st_d   = res_st_q;
    res_slot_d = res_slot_q;
    res_ord_d  = res_ord_q;
    res_lp_d   = res_lp_q;
    res_fl_d   = res_fl_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rsp_d      = rsp_q;

    tag_we     = 1'b0;
    tag_waddr  = take_idx;
    tag_wdata  = nro_q;
    tag_raddr  = (state_q == S_IDLE) ? req_i.payload.slot : scan_c_q[SLOT_W-1:0];
    start_scan = 1'b0;
    push_en    = 1'b0;
    push_slot  = slot_q;

    slot_ok  = ({1'b0, slot_q} < count_q);
    tgt_ph   = (op_q == OP_READ_DONE) ? PH_FULL : PH_FIN;
    take_idx = flv_q[head_q] ? fl_rdata : head_q;
    home_sum = {1'b0, total_q} + {1'b0, cnt_q};
    cur_ph   = phase_q[pidx_q];

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          op_d       = req_i.payload.operation;
          slot_d     = req_i.payload.slot;
          rd_last_d  = (req_i.payload.io_status == IO_EOF) || req_i.payload.status_eof ||
                       ((req_i.payload.io_status == IO_OK) &&
                        (req_i.payload.bytes_done != req_i.payload.bytes_requested));
          rd_fault_d = req_i.payload.io_status[1];
          wr_fault_d = (req_i.payload.io_status != IO_OK);
          res_st_d   = ST_OK;
          res_slot_d = '0;
          res_ord_d  = '0;
          res_lp_d   = 1'b0;
          res_fl_d   = 1'b0;
          state_d    = S_EXEC;
        end
      end

      S_EXEC: begin
        // Flag scan afterwards unless an arm below chooses otherwise.
        start_scan = 1'b1;
        mode_d     = M_FLAGS;
        a_ph_d     = PH_FULL;
        a_nf_d     = 1'b0;
        priority case (op_q)
          OP_TAKE_FREE: begin
            if (total_q == '0) begin
              res_st_d = ST_NONE;
            end else begin
              tag_we            = 1'b1;
              phase_d[take_idx] = PH_OUT;
              nro_d             = nro_q + 1'b1;
              head_d            = head_q + 1'b1;
              total_d           = total_q - 1'b1;
              res_slot_d        = take_idx;
              res_ord_d         = nro_q;
              res_lp_d          = final_q[take_idx];
              res_fl_d          = fault_q[take_idx];
            end
          end
          OP_READ_DONE, OP_WRITE_DONE: begin
            if (!slot_ok) begin
              res_st_d = ST_BAD_SLOT;
            end else if (phase_q[slot_q] != PH_OUT) begin
              res_st_d = (phase_q[slot_q] == tgt_ph) ? ST_DUP : ST_BAD_SLOT;
            end else begin
              key_d  = tag_rdata;
              mode_d = M_CLASH;
            end
          end
          OP_TAKE_FULL: begin
            if (!full_hit_q || (full_tag_q != nwo_q)) begin
              res_st_d = ST_NONE;
            end else begin
              phase_d[full_idx_q] = PH_OUT;
              if (!fault_q[full_idx_q]) begin
                if (final_q[full_idx_q]) begin
                  wr_done_d = 1'b1;
                end
                nwo_d = nwo_q + 1'b1;
              end
              res_slot_d = full_idx_q;
              res_ord_d  = full_tag_q;
              res_lp_d   = final_q[full_idx_q];
              res_fl_d   = fault_q[full_idx_q];
            end
          end
          OP_TAKE_FINISHED: begin
            if (!fin_hit_q || (fin_tag_q != nfo_q)) begin
              res_st_d = ST_NONE;
            end else begin
              phase_d[fin_idx_q] = PH_OUT;
              res_slot_d = fin_idx_q;
              res_ord_d  = fin_tag_q;
              res_lp_d   = final_q[fin_idx_q];
              res_fl_d   = fault_q[fin_idx_q];
            end
          end
          OP_MARK_COMPLETE: begin
            nfo_d = nfo_q + 1'b1;
          end
          OP_RETURN_FREE: begin
            if (!slot_ok) begin
              res_st_d = ST_BAD_SLOT;
            end else if (phase_q[slot_q] == PH_FREE) begin
              res_st_d = ST_DUP;
            end else begin
              push_en = 1'b1;
            end
          end
          OP_RESTART: begin
            if (src_done_q) begin
              mode_d = M_DRAIN;
              a_nf_d = 1'b1;
            end else begin
              start_scan = 1'b0;
              state_d    = S_RST;
            end
          end
          OP_FORCE_HOME: begin
            mode_d = M_DRAIN;
          end
          default: begin
          end
        endcase
      end

      S_SCAN: begin
        if (scan_c_q < count_q) begin
          pv_d     = 1'b1;
          pidx_d   = scan_c_q[SLOT_W-1:0];
          scan_c_d = scan_c_q + 1'b1;
        end else begin
          pv_d = 1'b0;
        end
        if (pv_q) begin
          if ((cur_ph == a_ph_q) && (!a_nf_q || final_q[pidx_q]) &&
              (!a_found_q || (tag_rdata < a_tag_q))) begin
            a_found_d = 1'b1;
            a_idx_d   = pidx_q;
            a_tag_d   = tag_rdata;
          end
          if ((cur_ph == PH_FIN) && (!b_found_q || (tag_rdata < b_tag_q))) begin
            b_found_d = 1'b1;
            b_idx_d   = pidx_q;
            b_tag_d   = tag_rdata;
          end
          if ((cur_ph == PH_FULL) || (cur_ph == PH_FIN)) begin
            cnt_d = cnt_q + 1'b1;
          end
          if ((pidx_q != slot_q) && (cur_ph == tgt_ph) && (tag_rdata == key_q)) begin
            clash_d = 1'b1;
          end
        end else if (scan_c_q == count_q) begin
          unique case (mode_q)
            M_FLAGS: begin
              full_hit_d = a_found_q;
              full_idx_d = a_idx_q;
              full_tag_d = a_tag_q;
              fin_hit_d  = b_found_q;
              fin_idx_d  = b_idx_q;
              fin_tag_d  = b_tag_q;
              home_d     = (home_sum == {1'b0, count_q});
              state_d    = S_DONE;
            end
            M_CLASH: begin
              if (clash_q) begin
                res_st_d = ST_DUP;
              end else if (op_q == OP_READ_DONE) begin
                final_d[slot_q] = rd_last_q;
                fault_d[slot_q] = rd_fault_q;
                if (rd_last_q) begin
                  src_done_d = 1'b1;
                end
                phase_d[slot_q] = PH_FULL;
              end else begin
                fault_d[slot_q] = wr_fault_q;
                phase_d[slot_q] = PH_FIN;
              end
              start_scan = 1'b1;
              mode_d     = M_FLAGS;
            end
            M_DRAIN: begin
              if (a_found_q) begin
                push_en    = 1'b1;
                push_slot  = a_idx_q;
                start_scan = 1'b1;
              end else if ((op_q == OP_FORCE_HOME) && (a_ph_q == PH_FULL)) begin
                a_ph_d     = PH_FIN;
                start_scan = 1'b1;
              end else if (op_q == OP_FORCE_HOME) begin
                start_scan = 1'b1;
                mode_d     = M_FLAGS;
                a_ph_d     = PH_FULL;
                a_nf_d     = 1'b0;
              end else begin
                state_d = S_RST;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_RST: begin
        if (total_q != count_q) begin
          res_st_d = ST_IN_USE;
        end else begin
          src_done_d = 1'b0;
          wr_done_d  = 1'b0;
          nro_d      = '0;
          nwo_d      = '0;
          nfo_d      = '0;
        end
        start_scan = 1'b1;
        mode_d     = M_FLAGS;
        a_ph_d     = PH_FULL;
        a_nf_d     = 1'b0;
      end

      S_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d          = 1'b1;
          rsp_d.status         = res_st_q;
          rsp_d.slot_out       = res_slot_q;
          rsp_d.order_out      = res_ord_q;
          rsp_d.last_part      = res_lp_q;
          rsp_d.io_failed      = res_fl_q;
          rsp_d.read_possible  = (total_q != '0) && !src_done_q;
          rsp_d.write_possible = !wr_done_q && full_hit_q && (full_tag_q == nwo_q);
          rsp_d.finished_ready = fin_hit_q && (fin_tag_q == nfo_q);
          rsp_d.all_home       = home_q;
          state_d              = S_IDLE;
        end
      end

      S_GROW: begin
        push_en   = 1'b1;
        push_slot = grow_q[SLOT_W-1:0];
        grow_d    = grow_q + 1'b1;
        if (grow_d == count_q) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Append a slot at the tail of the free list.
    fl_we    = 1'b0;
    fl_waddr = head_q + total_q[SLOT_W-1:0];
    fl_wdata = push_slot;
    if (push_en) begin
      phase_d[push_slot] = PH_FREE;
      if (total_q < CNT_W'(SLOTS)) begin
        fl_we           = 1'b1;
        flv_d[fl_waddr] = 1'b1;
        total_d         = total_q + 1'b1;
      end
    end

    if (start_scan) begin
      state_d   = S_SCAN;
      scan_c_d  = '0;
      pv_d      = 1'b0;
      a_found_d = 1'b0;
      b_found_d = 1'b0;
      cnt_d     = '0;
      clash_d   = 1'b0;
    end

    // Configuration: only takes effect while every slot in use is free.
    cfg_n = cfg_wdata_i;
    if (cfg_n == '0) begin
      cfg_n = CNT_W'(1);
    end else if (cfg_n > CNT_W'(SLOTS)) begin
      cfg_n = CNT_W'(SLOTS);
    end
    if (cfg_we_i && (total_q == count_q) && (cfg_n != count_q)) begin
      count_d = cfg_n;
      if (cfg_n < count_q) begin
        head_d  = '0;
        total_d = cfg_n;
        flv_d   = '0;
      end else begin
        grow_d  = count_q;
        state_d = S_GROW;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= CNT_W'(SLOTS);
      head_q      <= '0;
      total_q     <= CNT_W'(SLOTS);
      nro_q       <= '0;
      nwo_q       <= '0;
      nfo_q       <= '0;
      src_done_q  <= 1'b0;
      wr_done_q   <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        phase_q[i] <= PH_FREE;
      end
      final_q     <= '0;
      fault_q     <= '0;
      flv_q       <= '0;
      full_hit_q  <= 1'b0;
      fin_hit_q   <= 1'b0;
      home_q      <= 1'b1;
      mode_q      <= M_FLAGS;
      a_ph_q      <= PH_FULL;
      a_nf_q      <= 1'b0;
      scan_c_q    <= '0;
      pv_q        <= 1'b0;
      a_found_q   <= 1'b0;
      b_found_q   <= 1'b0;
      clash_q     <= 1'b0;
      cnt_q       <= '0;
      grow_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      head_q      <= head_d;
      total_q     <= total_d;
      nro_q       <= nro_d;
      nwo_q       <= nwo_d;
      nfo_q       <= nfo_d;
      src_done_q  <= src_done_d;
      wr_done_q   <= wr_done_d;
      phase_q     <= phase_d;
      final_q     <= final_d;
      fault_q     <= fault_d;
      flv_q       <= flv_d;
      full_hit_q  <= full_hit_d;
      fin_hit_q   <= fin_hit_d;
      home_q      <= home_d;
      mode_q      <= mode_d;
      a_ph_q      <= a_ph_d;
      a_nf_q      <= a_nf_d;
      scan_c_q    <= scan_c_d;
      pv_q        <= pv_d;
      a_found_q   <= a_found_d;
      b_found_q   <= b_found_d;
      clash_q     <= clash_d;
      cnt_q       <= cnt_d;
      grow_q      <= grow_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    slot_q     <= slot_d;
    rd_last_q  <= rd_last_d;
    rd_fault_q <= rd_fault_d;
    wr_fault_q <= wr_fault_d;
    key_q      <= key_d;
    full_idx_q <= full_idx_d;
    full_tag_q <= full_tag_d;
    fin_idx_q  <= fin_idx_d;
    fin_tag_q  <= fin_tag_d;
    pidx_q     <= pidx_d;
    a_idx_q    <= a_idx_d;
    a_tag_q    <= a_tag_d;
    b_idx_q    <= b_idx_d;
    b_tag_q    <= b_tag_d;
    res_st_q   <= res_st_d;
    res_slot_q <= res_slot_d;
    res_ord_q  <= res_ord_d;
    res_lp_q   <= res_lp_d;
    res_fl_q   <= res_fl_d;
    rsp_q      <= rsp_d;
  end

  // In the idle state, the free list holds no more slots than are in use.
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (total_q <= count_q))
    else $error("free list larger than the slot count");

  // An accepted transaction always goes straight to execution.
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> (state_q == S_EXEC))
    else $error("accepted transaction not executed");

  // A failed operation hands out no slot.
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && (rsp_q.status != ST_OK)) |->
    ((rsp_q.slot_out == '0) && (rsp_q.order_out == '0) && !rsp_q.last_part))
    else $error("failed result carries a slot");

endmodule
